[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define IFR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// condition must never be true outside reset
`define IFR_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define IFR_ASSERT(lbl, clk, rst_n, prop)
`define IFR_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[hdl/ifr_pkg.sv]
// ----------------------------------------------------------------------------
// ifr_pkg
// types and constants shared by the image flip, rotate and invert engine
// ----------------------------------------------------------------------------
package ifr_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int PIX_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 3'd4;

    // transform codes, codes above rotate counter-clockwise pass through
    localparam logic [2:0] OP_INVERT  = 3'd0;
    localparam logic [2:0] OP_HMIRROR = 3'd1;
    localparam logic [2:0] OP_VMIRROR = 3'd2;
    localparam logic [2:0] OP_ROT_CW  = 3'd3;
    localparam logic [2:0] OP_ROT_CCW = 3'd4;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_FETCH_EARLY = 2'd1;
    localparam logic [1:0] ST_LOAD_OVER   = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_ch0;
        logic [7:0] in_ch1;
        logic [7:0] in_ch2;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_ch0;
        logic [7:0] out_ch1;
        logic [7:0] out_ch2;
        logic       out_last;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [2:0] op_mode;
        logic [8:0] img_width;
        logic [8:0] img_height;
        logic [7:0] max_value;
        logic       color_mode;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        op_mode:    OP_INVERT,
        img_width:  9'd256,
        img_height: 9'd256,
        max_value:  8'd255,
        color_mode: 1'b0
    };

    // decode of one accepted request
    typedef struct packed {
        logic       wr;
        logic       fetch_ok;
        logic       err;
        logic [1:0] status;
        logic       last;
    } t_req_info;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_DATA,
        S_ERR
    } t_state;

endpackage

[hdl/ifr_store.sv]
// ----------------------------------------------------------------------------
// ifr_store
// frame store, one write port and one registered read port
// ----------------------------------------------------------------------------
module ifr_store import ifr_pkg::*; #(
    parameter  int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter  int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW         = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [PIX_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ifr_agen.sv]
// ----------------------------------------------------------------------------
// ifr_agen
// load counter, output position counters and store address generation
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ifr_agen import ifr_pkg::*; #(
    parameter  int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter  int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW         = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  t_in_item      i_item,
    input  t_cfg          i_cfg,
    output t_req_info     o_info,
    output logic [AW-1:0] o_wr_addr,
    output logic [AW-1:0] o_rd_addr
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIMW = $clog2(MAXD + 1);
    localparam int PW   = $clog2(MAXD);

    logic [CW-1:0]   r_load_count;
    logic [PW-1:0]   r_row;
    logic [PW-1:0]   r_col;
    logic [PW-1:0]   r_sr;
    logic [PW-1:0]   r_sc;

    logic [DIMW-1:0] w;
    logic [DIMW-1:0] h;
    logic [DIMW-1:0] ow;
    logic [DIMW-1:0] oh;
    logic [CW-1:0]   total;
    logic            rotate;
    logic            restart;
    logic            full;
    logic            is_load;
    logic            last;
    logic            col_end;
    logic [PW-1:0]   row_e;
    logic [PW-1:0]   col_e;
    logic [DIMW-1:0] sr_d;
    logic [DIMW-1:0] sc_d;

    // clamp dimensions to 1..max
    always_comb begin
        if (i_cfg.img_width == '0) begin
            w = DIMW'(1);
        end else if (32'(i_cfg.img_width) > MAX_WIDTH) begin
            w = DIMW'(MAX_WIDTH);
        end else begin
            w = DIMW'(i_cfg.img_width);
        end
        if (i_cfg.img_height == '0) begin
            h = DIMW'(1);
        end else if (32'(i_cfg.img_height) > MAX_HEIGHT) begin
            h = DIMW'(MAX_HEIGHT);
        end else begin
            h = DIMW'(i_cfg.img_height);
        end
    end

    assign total  = CW'(w) * CW'(h);
    assign rotate = (i_cfg.op_mode == OP_ROT_CW) || (i_cfg.op_mode == OP_ROT_CCW);
    assign ow     = rotate ? h : w;
    assign oh     = rotate ? w : h;

    // position left outside the output size restarts the scan
    assign restart = (DIMW'(r_row) >= oh) || (DIMW'(r_col) >= ow);
    assign row_e   = restart ? '0 : r_row;
    assign col_e   = restart ? '0 : r_col;
    assign col_end = (DIMW'(col_e) == ow - DIMW'(1));
    assign last    = (DIMW'(row_e) == oh - DIMW'(1)) && col_end;

    always_comb begin
        case (i_cfg.op_mode)
            OP_HMIRROR: begin
                sr_d = DIMW'(row_e);
                sc_d = w - DIMW'(1) - DIMW'(col_e);
            end
            OP_VMIRROR: begin
                sr_d = h - DIMW'(1) - DIMW'(row_e);
                sc_d = DIMW'(col_e);
            end
            OP_ROT_CW: begin
                sr_d = h - DIMW'(1) - DIMW'(col_e);
                sc_d = DIMW'(row_e);
            end
            OP_ROT_CCW: begin
                sr_d = DIMW'(col_e);
                sc_d = w - DIMW'(1) - DIMW'(row_e);
            end
            default: begin
                sr_d = DIMW'(row_e);
                sc_d = DIMW'(col_e);
            end
        endcase
    end

    assign is_load = (i_item.req_type == REQ_LOAD);
    assign full    = (r_load_count >= total);

    always_comb begin
        o_info.wr       = is_load && !full;
        o_info.fetch_ok = !is_load && full;
        o_info.err      = is_load ? full : !full;
        o_info.status   = is_load ? ST_LOAD_OVER : ST_FETCH_EARLY;
        o_info.last     = !is_load && full && last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
            r_row        <= '0;
            r_col        <= '0;
        end else if (i_accept) begin
            if (o_info.wr) begin
                r_load_count <= r_load_count + CW'(1);
            end else if (o_info.fetch_ok) begin
                if (last) begin
                    r_row        <= '0;
                    r_col        <= '0;
                    r_load_count <= '0;
                end else if (col_end) begin
                    r_row <= row_e + PW'(1);
                    r_col <= '0;
                end else begin
                    r_row <= row_e;
                    r_col <= col_e + PW'(1);
                end
            end
        end
    end

    // source coordinates held for the address stage
    always_ff @(posedge i_clk) begin
        if (i_accept && o_info.fetch_ok) begin
            r_sr <= PW'(sr_d);
            r_sc <= PW'(sc_d);
        end
    end

    assign o_wr_addr = r_load_count[AW-1:0];
    assign o_rd_addr = AW'(r_sr) * AW'(w) + AW'(r_sc);

    `IFR_ASSERT(a_last_frees_frame, i_clk, i_rst_n, (i_accept && o_info.last) |=> (r_load_count == '0))
    `IFR_ASSERT(a_load_counts_one, i_clk, i_rst_n, (i_accept && o_info.wr) |=> (r_load_count == $past(r_load_count) + CW'(1)))

endmodule

[hdl/image_flip_rotate_invert_core.sv]
// load beat: stored loads are taken in idle, back to back at one pixel per clock
// fetch beat: idle, address, data (held while output is full), then the output register;
// next beat is taken back in idle. The fetch path is set by the address stage (row times
// width multiply) and the registered store read; a flagged beat goes via the error state
// reset clears counters, control and config registers to defaults; the store is not cleared
// ----------------------------------------------------------------------------
// image_flip_rotate_invert_core
// frame engine: loads pixels in raster order, returns them inverted, mirrored
// or rotated by 90 degrees in output raster order
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module image_flip_rotate_invert_core import ifr_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request beats
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    t_cfg             r_cfg;
    t_state           r_state;
    t_state           n_state;
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_out_item        n_out_item;
    logic             r_pend_last;
    logic [1:0]       r_pend_status;

    logic             accept;
    logic             out_free;
    logic             out_load;
    logic             mem_we;
    logic             mem_re;
    logic [PIX_W-1:0] mem_wdata;
    logic [PIX_W-1:0] mem_rdata;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    t_req_info        info;
    logic [7:0]       c0;
    logic [7:0]       c1;
    logic [7:0]       c2;

    // inversion saturates to zero above max value
    function automatic logic [7:0] f_invert(input logic [7:0] s, input logic [7:0] m);
        return (s > m) ? 8'd0 : (m - s);
    endfunction

    // ------------------------------------------------------------------
    // configuration registers, writes to unknown indexes are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OP_MODE:    r_cfg.op_mode    <= i_cfg_data[2:0];
                CFG_IMG_WIDTH:  r_cfg.img_width  <= i_cfg_data[8:0];
                CFG_IMG_HEIGHT: r_cfg.img_height <= i_cfg_data[8:0];
                CFG_MAX_VALUE:  r_cfg.max_value  <= i_cfg_data[7:0];
                CFG_COLOR_MODE: r_cfg.color_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // counters and address generation
    // ------------------------------------------------------------------
    assign accept = i_in_valid && o_in_ready;

    ifr_agen #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_agen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_in_item),
        .i_cfg     (r_cfg),
        .o_info    (info),
        .o_wr_addr (wr_addr),
        .o_rd_addr (rd_addr)
    );

    // ------------------------------------------------------------------
    // frame store, greyscale loads keep green and blue at zero
    // ------------------------------------------------------------------
    assign mem_we    = accept && info.wr;
    assign mem_wdata = {r_cfg.color_mode ? i_in_item.in_ch2 : 8'd0,
                        r_cfg.color_mode ? i_in_item.in_ch1 : 8'd0,
                        i_in_item.in_ch0};

    ifr_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (wr_addr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // sequencer: idle takes a beat, fetches go through address and data
    // stages, flagged beats go straight to the result stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        mem_re     = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (info.fetch_ok) begin
                        n_state = S_ADDR;
                    end else if (info.err) begin
                        n_state = S_ERR;
                    end
                end
            end
            S_ADDR: begin
                mem_re  = 1'b1;
                n_state = S_DATA;
            end
            S_DATA, S_ERR: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // what the accepted beat leaves for the result stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_last   <= info.last;
            r_pend_status <= info.status;
        end
    end

    // ------------------------------------------------------------------
    // pixel transform on the store read data
    // ------------------------------------------------------------------
    always_comb begin
        c0 = mem_rdata[7:0];
        c1 = mem_rdata[15:8];
        c2 = mem_rdata[23:16];
        if (r_cfg.op_mode == OP_INVERT) begin
            c0 = f_invert(c0, r_cfg.max_value);
            c1 = f_invert(c1, r_cfg.max_value);
            c2 = f_invert(c2, r_cfg.max_value);
        end
        if (!r_cfg.color_mode) begin
            c1 = 8'd0;
            c2 = 8'd0;
        end
        if (r_state == S_ERR) begin
            n_out_item = '{out_ch0: 8'd0, out_ch1: 8'd0, out_ch2: 8'd0,
                           out_last: 1'b0, status: r_pend_status};
        end else begin
            n_out_item = '{out_ch0: c0, out_ch1: c1, out_ch2: c2,
                           out_last: r_pend_last, status: ST_OK};
        end
    end

    // ------------------------------------------------------------------
    // output register, holds a finished beat until it is taken
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `IFR_ASSERT(a_addr_then_data, i_clk, i_rst_n, (r_state == S_ADDR) |=> (r_state == S_DATA))
    `IFR_ASSERT(a_flag_beat_clean, i_clk, i_rst_n, (o_out_valid && (o_out_item.status != ST_OK)) |-> (!o_out_item.out_last && (o_out_item.out_ch0 == 8'd0)))
    `IFR_NEVER(a_no_rw_overlap, i_clk, i_rst_n, mem_we && mem_re)
    `IFR_ASSERT(a_result_lands, i_clk, i_rst_n, out_load |=> (o_out_valid && (r_state == S_IDLE)))

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the frame flip, rotate and invert engine: a queue of
// load and fetch beats, register writes and drain points is replayed through a
// bursty driver, every accepted beat is run through a frame predictor, and the
// result beats are checked field by field against the expected pixels in order
// ----------------------------------------------------------------------------
module tb_top;
    import ifr_pkg::*;

    // top of the op_mode range, decodes as a plain pass-through
    localparam logic [2:0] OP_UNUSED_TOP = 3'd7;

    localparam int SETTLE_CYC = 8;      // quiet cycles before a register write
    localparam int HOLD_CYC   = 400;    // long receiver back-pressure stretch
    localparam int TAIL_CYC   = 16;     // cycles after the last result beat
    localparam int RAND_BEATS = 320;    // request beats spent on random frames

    // what the driver does with the head of the queue
    typedef enum logic [1:0] {
        DO_BEAT,    // offer one request beat
        DO_DRAIN,   // wait until every expected pixel is back, then settle
        DO_WRITE,   // one register write
        DO_HOLD     // ask the receiver for a long stall
    } t_step_kind;

    typedef struct {
        t_step_kind            kind;
        t_in_item              beat;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_step;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,    // always ready
        RX_COIN,    // ready half the time
        RX_SPARSE,  // ready one cycle in four on average
        RX_TOGGLE   // ready every other cycle
    } t_rx_mode;

    // dut connections, all inputs known from time zero
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    t_in_item              in_item    = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    t_out_item             out_item;

    // stimulus and scoreboard
    t_step     stim_q[$];
    t_out_item exp_pixels[$];
    int        beat_cnt    = 0;
    int        err_cnt     = 0;
    int        hold_asked  = 0;
    int        hold_taken  = 0;

    // predictor state: shadow registers, frame store and raster position
    t_cfg        cfg_sh     = CFG_RESET;
    logic [23:0] frm_pix [0:65535];
    int          loaded_cnt = 0;
    int          row_pos    = 0;
    int          col_pos    = 0;

    // sender burst shaping
    int burst_left = 1;
    int gap_left   = 0;
    int settle_cnt = 0;

    image_flip_rotate_invert_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // frame predictor
    // ------------------------------------------------------------------------

    // register value to frame dimension, zero and oversize values are clamped
    function automatic int dim_of(logic [8:0] v, int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // inversion saturates at zero for samples above max_value
    function automatic logic [7:0] inv_sample(logic [7:0] s);
        return (s > cfg_sh.max_value) ? 8'd0 : cfg_sh.max_value - s;
    endfunction

    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_OP_MODE:    cfg_sh.op_mode    = data[2:0];
            CFG_IMG_WIDTH:  cfg_sh.img_width  = data[8:0];
            CFG_IMG_HEIGHT: cfg_sh.img_height = data[8:0];
            CFG_MAX_VALUE:  cfg_sh.max_value  = data[7:0];
            CFG_COLOR_MODE: cfg_sh.color_mode = data[0];
            default: ;
        endcase
    endfunction

    // one accepted request beat: update the frame state, queue any result
    function automatic void frame_step(t_in_item it);
        int          w, h, total, ow, oh, sr, sc;
        logic        rot;
        logic [23:0] px;
        logic [7:0]  c0, c1, c2;
        t_out_item   r;
        w     = dim_of(cfg_sh.img_width, DEF_MAX_WIDTH);
        h     = dim_of(cfg_sh.img_height, DEF_MAX_HEIGHT);
        total = w * h;
        rot   = (cfg_sh.op_mode == OP_ROT_CW) || (cfg_sh.op_mode == OP_ROT_CCW);
        ow    = rot ? h : w;
        oh    = rot ? w : h;
        r     = '0;
        if (it.req_type == REQ_LOAD) begin
            if (loaded_cnt >= total) begin
                // frame already full, nothing stored
                r.status = ST_LOAD_OVER;
                exp_pixels.push_back(r);
            end else begin
                // greyscale keeps channel 0 only
                frm_pix[loaded_cnt] = cfg_sh.color_mode ?
                    {it.in_ch2, it.in_ch1, it.in_ch0} : {16'd0, it.in_ch0};
                loaded_cnt++;
            end
        end else if (loaded_cnt < total) begin
            r.status = ST_FETCH_EARLY;
            exp_pixels.push_back(r);
        end else begin
            // geometry changed under a running frame: restart the raster
            if (row_pos >= oh || col_pos >= ow) begin
                row_pos = 0;
                col_pos = 0;
            end
            case (cfg_sh.op_mode)
                OP_HMIRROR: begin sr = row_pos;         sc = w - 1 - col_pos; end
                OP_VMIRROR: begin sr = h - 1 - row_pos; sc = col_pos;         end
                OP_ROT_CW:  begin sr = h - 1 - col_pos; sc = row_pos;         end
                OP_ROT_CCW: begin sr = col_pos;         sc = w - 1 - row_pos; end
                default:    begin sr = row_pos;         sc = col_pos;         end
            endcase
            px = frm_pix[sr * w + sc];
            c0 = px[7:0];
            c1 = px[15:8];
            c2 = px[23:16];
            if (cfg_sh.op_mode == OP_INVERT) begin
                c0 = inv_sample(c0);
                c1 = inv_sample(c1);
                c2 = inv_sample(c2);
            end
            if (!cfg_sh.color_mode) begin
                c1 = 8'd0;
                c2 = 8'd0;
            end
            r.out_ch0  = c0;
            r.out_ch1  = c1;
            r.out_ch2  = c2;
            r.out_last = (row_pos == oh - 1) && (col_pos == ow - 1);
            r.status   = ST_OK;
            exp_pixels.push_back(r);
            // advance the output raster, last pixel releases the frame
            if (r.out_last) begin
                row_pos    = 0;
                col_pos    = 0;
                loaded_cnt = 0;
            end else if (col_pos == ow - 1) begin
                col_pos = 0;
                row_pos++;
            end else begin
                col_pos++;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // queue builders
    // ------------------------------------------------------------------------

    task automatic put_beat(logic rt, logic [7:0] a, logic [7:0] b, logic [7:0] c);
        t_step s;
        s.kind          = DO_BEAT;
        s.beat.req_type = rt;
        s.beat.in_ch0   = a;
        s.beat.in_ch1   = b;
        s.beat.in_ch2   = c;
        s.idx           = '0;
        s.data          = '0;
        stim_q.push_back(s);
        beat_cnt++;
    endtask

    task automatic put_rand(logic rt);
        put_beat(rt, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic put_marker(t_step_kind k);
        t_step s;
        s.kind = k;
        s.beat = '0;
        s.idx  = '0;
        s.data = '0;
        stim_q.push_back(s);
    endtask

    task automatic put_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_step s;
        s.kind = DO_WRITE;
        s.beat = '0;
        s.idx  = idx;
        s.data = data;
        stim_q.push_back(s);
    endtask

    // full register set, only once the engine has gone quiet
    task automatic put_cfg(logic [2:0] op, logic [8:0] wr, logic [8:0] hr,
                           logic [7:0] mx, logic col);
        put_marker(DO_DRAIN);
        put_write(CFG_OP_MODE, CFG_DATA_W'(op));
        put_write(CFG_IMG_WIDTH, wr);
        put_write(CFG_IMG_HEIGHT, hr);
        put_write(CFG_MAX_VALUE, CFG_DATA_W'(mx));
        put_write(CFG_COLOR_MODE, CFG_DATA_W'(col));
    endtask

    // one well-formed frame with random content, optionally with stray beats
    // and a transform change half way through readout
    task automatic frame_run(logic [2:0] op, logic [8:0] wr, logic [8:0] hr,
                             logic [7:0] mx, logic col, logic hold, logic noisy);
        int         n, half, v;
        logic [2:0] op2;
        put_cfg(op, wr, hr, mx, col);
        n    = dim_of(wr, DEF_MAX_WIDTH) * dim_of(hr, DEF_MAX_HEIGHT);
        half = n / 2;
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 24) == 0)
                put_rand(REQ_FETCH);
            put_rand(REQ_LOAD);
        end
        if (noisy && $urandom_range(0, 5) == 0)
            put_rand(REQ_LOAD);
        if (hold)
            put_marker(DO_HOLD);
        for (int i = 0; i < n; i++) begin
            if (i == half && noisy && $urandom_range(0, 7) == 0) begin
                // stay within the same output geometry
                if (op == OP_ROT_CW || op == OP_ROT_CCW) begin
                    op2 = 3'($urandom_range(3, 4));
                end else begin
                    v   = $urandom_range(0, 5);
                    op2 = 3'((v < 3) ? v : v + 2);
                end
                put_marker(DO_DRAIN);
                put_write(CFG_OP_MODE, CFG_DATA_W'(op2));
                put_write(CFG_MAX_VALUE, 9'($urandom_range(0, 255)));
                put_write(CFG_COLOR_MODE, 9'($urandom_range(0, 1)));
            end
            put_rand(REQ_FETCH);
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: bursts of beats with random gaps, writes only when quiet
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : drv_proc
        logic                  nv, nwe;
        t_in_item              ni;
        logic [CFG_IDX_W-1:0]  nidx;
        logic [CFG_DATA_W-1:0] ndata;
        t_step                 cur;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_item  <= '0;
            cfg_we   <= 1'b0;
            cfg_idx  <= '0;
            cfg_data <= '0;
        end else begin
            nv    = in_valid;
            ni    = in_item;
            nwe   = 1'b0;
            nidx  = cfg_idx;
            ndata = cfg_data;
            if (in_valid && in_ready) begin
                frame_step(in_item);
                nv = 1'b0;
            end
            // at most one queue entry per cycle, next beat may follow back to back
            if (!nv && stim_q.size() != 0) begin
                case (stim_q[0].kind)
                    DO_BEAT: begin
                        if (gap_left != 0) begin
                            gap_left--;
                        end else begin
                            cur = stim_q.pop_front();
                            nv  = 1'b1;
                            ni  = cur.beat;
                            burst_left--;
                            if (burst_left <= 0) begin
                                burst_left = $urandom_range(1, 40);
                                gap_left   = ($urandom_range(0, 3) == 0) ?
                                             0 : $urandom_range(1, 12);
                            end
                        end
                    end
                    DO_DRAIN: begin
                        // results may still be in flight, then allow load latency
                        if (exp_pixels.size() == 0) begin
                            settle_cnt++;
                            if (settle_cnt >= SETTLE_CYC) begin
                                settle_cnt = 0;
                                cur = stim_q.pop_front();
                            end
                        end else begin
                            settle_cnt = 0;
                        end
                    end
                    DO_WRITE: begin
                        cur   = stim_q.pop_front();
                        nwe   = 1'b1;
                        nidx  = cur.idx;
                        ndata = cur.data;
                        apply_write(cur.idx, cur.data);
                    end
                    default: begin
                        cur = stim_q.pop_front();
                        hold_asked++;
                    end
                endcase
            end
            in_valid <= nv;
            in_item  <= ni;
            cfg_we   <= nwe;
            cfg_idx  <= nidx;
            cfg_data <= ndata;
        end
    end

    // ------------------------------------------------------------------------
    // receiver: stall pattern of its own plus long holds on request
    // ------------------------------------------------------------------------
    t_rx_mode rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;

    always @(posedge clk) begin : rcv_proc
        logic rdy;
        rdy = 1'b0;
        if (rst_n) begin
            if (hold_taken != hold_asked) begin
                hold_taken++;
                hold_left = HOLD_CYC;
            end
            if (hold_left != 0) begin
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 128);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_COIN:   rdy = 1'($urandom_range(0, 1));
                    RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                    default:   rdy = ~out_ready;
                endcase
            end
        end
        out_ready <= rdy;
    end

    // ------------------------------------------------------------------------
    // monitor: every result beat against the oldest expected pixel
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge clk) begin : mon_proc
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (exp_pixels.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %p",
                         $time, out_item);
                err_cnt++;
            end else begin
                want = exp_pixels.pop_front();
                check_field("out_ch0", want.out_ch0, out_item.out_ch0);
                check_field("out_ch1", want.out_ch1, out_item.out_ch1);
                check_field("out_ch2", want.out_ch2, out_item.out_ch2);
                check_field("out_last", want.out_last, out_item.out_last);
                check_field("status", want.status, out_item.status);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : main_proc
        int         frame_no, rand_base;
        logic [8:0] wr, hr;
        logic [2:0] op;

        // fetch straight after reset, the default 256 x 256 frame is empty
        put_beat(REQ_FETCH, 8'h00, 8'h00, 8'h00);

        // grey inversion at full range and a load overrun
        put_cfg(OP_INVERT, 9'd2, 9'd2, 8'd255, 1'b0);
        put_beat(REQ_LOAD, 8'd0, 8'hAA, 8'h55);
        put_beat(REQ_LOAD, 8'd255, 8'hFF, 8'hFF);
        put_beat(REQ_LOAD, 8'd1, 8'h01, 8'h80);
        put_beat(REQ_LOAD, 8'd128, 8'h7F, 8'hFE);
        put_beat(REQ_LOAD, 8'h11, 8'h22, 8'h33);
        repeat (4) put_beat(REQ_FETCH, 8'hFF, 8'hFF, 8'hFF);

        // rgb inversion with samples above max_value saturating
        put_cfg(OP_INVERT, 9'd1, 9'd2, 8'd100, 1'b1);
        put_beat(REQ_LOAD, 8'd200, 8'd100, 8'd0);
        put_beat(REQ_LOAD, 8'd99, 8'd255, 8'd1);
        repeat (2) put_beat(REQ_FETCH, 8'h00, 8'h00, 8'h00);

        // zero width clamps to one, unused op code passes the pixel through
        put_cfg(OP_UNUSED_TOP, 9'd0, 9'd1, 8'd0, 1'b0);
        put_beat(REQ_LOAD, 8'h5A, 8'hC3, 8'h3C);
        put_beat(REQ_FETCH, 8'h00, 8'h00, 8'h00);

        // height cut under a running readout restarts the output raster
        put_cfg(OP_HMIRROR, 9'd3, 9'd2, 8'd255, 1'b1);
        for (int i = 0; i < 6; i++)
            put_beat(REQ_LOAD, 8'(i * 40), 8'(255 - i), 8'(i * 7));
        repeat (4) put_beat(REQ_FETCH, 8'h00, 8'h00, 8'h00);
        put_marker(DO_DRAIN);
        put_write(CFG_IMG_HEIGHT, 9'd1);
        repeat (3) put_beat(REQ_FETCH, 8'h00, 8'h00, 8'h00);

        // oversize width clamps to a full row, overruns and a few rotated
        // pixels under a held receiver, then a 1 x 1 readout frees the store
        put_cfg(OP_ROT_CW, 9'd300, 9'd1, 8'($urandom), 1'b1);
        for (int i = 0; i < DEF_MAX_WIDTH; i++)
            put_rand(REQ_LOAD);
        put_marker(DO_HOLD);
        repeat (4) put_rand(REQ_LOAD);
        repeat (8) put_rand(REQ_FETCH);
        put_cfg(OP_INVERT, 9'd1, 9'd1, 8'd255, 1'b1);
        put_rand(REQ_FETCH);

        // random frames, mostly small, with stray beats mixed in
        frame_no  = 0;
        rand_base = beat_cnt;
        while (beat_cnt - rand_base < RAND_BEATS) begin
            op = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0:       wr = 9'd0;
                1:       wr = 9'($urandom_range(9, 20));
                default: wr = 9'($urandom_range(1, 8));
            endcase
            if (dim_of(wr, DEF_MAX_WIDTH) > 8) begin
                hr = 9'($urandom_range(0, 3));
            end else begin
                case ($urandom_range(0, 9))
                    0:       hr = 9'd0;
                    1:       hr = 9'($urandom_range(9, 12));
                    default: hr = 9'($urandom_range(1, 8));
                endcase
            end
            frame_run(op, wr, hr, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      (frame_no % 11) == 5, 1'b1);
            frame_no++;
        end

        // reset, then let the driver and monitor run the queue down
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (stim_q.size() != 0 || in_valid || exp_pixels.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial begin : limit_proc
        #12000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
